[hdl/vector_matrix_alu_macros.svh]
// assertion macros shared by the vector matrix alu
`ifndef VECTOR_MATRIX_ALU_MACROS_SVH
`define VECTOR_MATRIX_ALU_MACROS_SVH

// same-cycle implication
`define VMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vma_pkg.sv]
// types, constants and helpers for the vector matrix alu
`timescale 1ns / 1ps

package vma_pkg;

  localparam int NUM_LANES   = 4;
  localparam int NUM_TERMS   = 4;
  localparam int COMP_W      = 16;
  localparam int OPND_W      = COMP_W + 1;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int FRAC_W      = 8;
  localparam int QUOT_W      = SUM_W - FRAC_W;
  localparam int CFG_W       = 64;
  localparam int NUM_REGS    = 4;
  localparam int ADDR_W      = 5;
  localparam int IDX_LSB     = 3;
  localparam int IDX_W       = 2;

  localparam logic signed [OPND_W-1:0] ONE_OPND     = 17'sd256;
  localparam logic signed [OPND_W-1:0] NEG_ONE_OPND = -17'sd256;
  localparam logic signed [COMP_W-1:0] ONE_Q88      = 16'sd256;
  localparam logic signed [COMP_W-1:0] COMP_MAX     = 16'sh7fff;
  localparam logic signed [COMP_W-1:0] COMP_MIN     = 16'sh8000;
  localparam logic signed [SUM_W-1:0]  RND_HALF     = 36'sd128;

  localparam logic [CFG_W-1:0] COL_X_RESET = 64'h0000_0000_0000_0100;
  localparam logic [CFG_W-1:0] COL_Y_RESET = 64'h0000_0000_0100_0000;
  localparam logic [CFG_W-1:0] COL_Z_RESET = 64'h0000_0100_0000_0000;
  localparam logic [CFG_W-1:0] COL_W_RESET = 64'h0100_0000_0000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_COL_X = 2'd0,
    REG_COL_Y = 2'd1,
    REG_COL_Z = 2'd2,
    REG_COL_W = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_NEG    = 3'd2,
    OP_SCALE  = 3'd3,
    OP_LERP   = 3'd4,
    OP_DOT    = 3'd5,
    OP_CROSS  = 3'd6,
    OP_XFORM  = 3'd7
  } op_t;

  typedef logic signed [OPND_W-1:0] opnd_t;

  typedef struct packed {
    opnd_t [NUM_TERMS-1:0] m;
    opnd_t [NUM_TERMS-1:0] n;
  } lane_ops_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctl_t;

  function automatic opnd_t ext17(input logic [COMP_W-1:0] x);
    return {x[COMP_W-1], x};
  endfunction

endpackage

[hdl/vector_matrix_alu.sv]
// vector matrix alu top level: config registers, pipeline control, lanes
// an accepted word passes the operand, product, sum and output registers to the outputs
// throughput: one word per cycle unless out_ready stalls, four lanes of four 17x17 multipliers each
// stages: operand select, products, lane sums, round/saturate/merge output
// stalls back up stage by stage; bubbles fill while a result word waits
// reset: synchronous, clears all valids and loads the identity matrix
`timescale 1ns / 1ps
`include "vector_matrix_alu_macros.svh"

module vector_matrix_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vma_pkg::ADDR_W-1:0]  paddr,
  input  logic [vma_pkg::CFG_W-1:0]   pwdata,
  output logic [vma_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  operation,
  input  logic signed [15:0]          ax,
  input  logic signed [15:0]          ay,
  input  logic signed [15:0]          az,
  input  logic signed [15:0]          aw,
  input  logic signed [15:0]          bx,
  input  logic signed [15:0]          by,
  input  logic signed [15:0]          bz,
  input  logic signed [15:0]          factor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          rx,
  output logic signed [15:0]          ry,
  output logic signed [15:0]          rz,
  output logic signed [15:0]          rw,
  output logic signed [15:0]          scalar,
  output logic                        saturated
);
  import vma_pkg::*;

  logic [NUM_REGS-1:0][CFG_W-1:0] matrix;
  reg_idx_t                       reg_idx;
  logic                           cfg_write;

  lane_ops_t [NUM_LANES-1:0]      ops_sel;
  lane_ops_t [NUM_LANES-1:0]      ops;
  logic signed [NUM_LANES-1:0][SUM_W-1:0] sums;
  lane_ctl_t                      ctl;

  logic v1;
  logic v2;
  logic v3;
  op_t  op1;
  op_t  op2;
  op_t  op3;
  logic free1;
  logic free2;
  logic free3;
  logic free_out;

  // config port
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[IDX_LSB +: IDX_W]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = matrix[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[REG_COL_X] <= COL_X_RESET;
      matrix[REG_COL_Y] <= COL_Y_RESET;
      matrix[REG_COL_Z] <= COL_Z_RESET;
      matrix[REG_COL_W] <= COL_W_RESET;
    end else if (cfg_write) begin
      matrix[reg_idx] <= pwdata;
    end
  end

  // pipeline control
  assign free3       = !v3 || free_out;
  assign free2       = !v2 || free3;
  assign free1       = !v1 || free2;
  assign in_ready    = free1;
  assign ctl.ld_prod = free2;
  assign ctl.ld_sum  = free3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (free1) begin
        v1 <= in_valid;
      end
      if (free2) begin
        v2 <= v1;
      end
      if (free3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      op1 <= op_t'(operation);
      ops <= ops_sel;
    end
    if (free2) begin
      op2 <= op1;
    end
    if (free3) begin
      op3 <= op2;
    end
  end

  vma_operand_sel u_operand_sel (
    .operation (op_t'(operation)),
    .ax        (ax),
    .ay        (ay),
    .az        (az),
    .aw        (aw),
    .bx        (bx),
    .by        (by),
    .bz        (bz),
    .factor    (factor),
    .matrix    (matrix),
    .ops       (ops_sel)
  );

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    vma_lane u_lane (
      .clk (clk),
      .ctl (ctl),
      .ops (ops[k]),
      .sum (sums[k])
    );
  end

  vma_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (v3),
    .sum_op    (op3),
    .sums      (sums),
    .free      (free_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rx        (rx),
    .ry        (ry),
    .rz        (rz),
    .rw        (rw),
    .scalar    (scalar),
    .saturated (saturated)
  );

  `VMA_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v1, "accepted word not in stage 1")
  `VMA_ASSERT_NEXT(a_stall_holds_s3, v3 && out_valid && !out_ready, v3, "stalled sum word lost")
  `VMA_ASSERT_NOW(a_ready_has_room, in_ready, !(v1 && v2 && v3 && out_valid && !out_ready), "ready with full pipe")
  `VMA_ASSERT_NOW(a_scalar_only_dot, out_valid && scalar != 16'sd0, rx == 16'sd0 && ry == 16'sd0 && rz == 16'sd0 && rw == ONE_Q88, "scalar with vector result")

endmodule

[hdl/vma_operand_sel.sv]
// per-lane multiplier operand selection by operation
`timescale 1ns / 1ps

module vma_operand_sel (
  input  vma_pkg::op_t                                   operation,
  input  logic signed [15:0]                             ax,
  input  logic signed [15:0]                             ay,
  input  logic signed [15:0]                             az,
  input  logic signed [15:0]                             aw,
  input  logic signed [15:0]                             bx,
  input  logic signed [15:0]                             by,
  input  logic signed [15:0]                             bz,
  input  logic signed [15:0]                             factor,
  input  logic [vma_pkg::NUM_REGS-1:0][vma_pkg::CFG_W-1:0] matrix,
  output vma_pkg::lane_ops_t [vma_pkg::NUM_LANES-1:0]    ops
);
  import vma_pkg::*;

  opnd_t av [NUM_LANES];
  opnd_t bv [NUM_LANES];
  opnd_t tv;

  assign av[0] = ext17(ax);
  assign av[1] = ext17(ay);
  assign av[2] = ext17(az);
  assign av[3] = ext17(aw);
  assign bv[0] = ext17(bx);
  assign bv[1] = ext17(by);
  assign bv[2] = ext17(bz);
  assign bv[3] = '0;
  assign tv    = ext17(factor);

  always_comb begin
    int j;
    int l;
    for (int k = 0; k < NUM_LANES; k++) begin
      j = (k == 0) ? 1 : ((k == 1) ? 2 : 0);
      l = (k == 0) ? 2 : ((k == 1) ? 0 : 1);
      ops[k] = '0;
      case (operation)
        OP_ADD: begin
          ops[k].m[0] = av[k];
          ops[k].n[0] = ONE_OPND;
          ops[k].m[1] = bv[k];
          ops[k].n[1] = ONE_OPND;
        end
        OP_SUB: begin
          ops[k].m[0] = av[k];
          ops[k].n[0] = ONE_OPND;
          ops[k].m[1] = bv[k];
          ops[k].n[1] = NEG_ONE_OPND;
        end
        OP_NEG: begin
          ops[k].m[0] = av[k];
          ops[k].n[0] = NEG_ONE_OPND;
        end
        OP_SCALE: begin
          ops[k].m[0] = av[k];
          ops[k].n[0] = tv;
        end
        OP_LERP: begin
          ops[k].m[0] = av[k];
          ops[k].n[0] = ONE_OPND;
          ops[k].m[1] = bv[k] - av[k];
          ops[k].n[1] = tv;
        end
        OP_DOT: begin
          for (int i = 0; i < 3; i++) begin
            ops[k].m[i] = av[i];
            ops[k].n[i] = bv[i];
          end
        end
        OP_CROSS: begin
          ops[k].m[0] = av[j];
          ops[k].n[0] = bv[l];
          ops[k].m[1] = av[l];
          ops[k].n[1] = -bv[j];
        end
        OP_XFORM: begin
          for (int i = 0; i < NUM_TERMS; i++) begin
            ops[k].m[i] = av[i];
            ops[k].n[i] = ext17(matrix[k][COMP_W*i +: COMP_W]);
          end
        end
        default: ops[k] = '0;
      endcase
    end
  end

endmodule

[hdl/vma_lane.sv]
// one lane: four registered products and their registered exact sum
`timescale 1ns / 1ps

module vma_lane (
  input  logic                               clk,
  input  vma_pkg::lane_ctl_t                 ctl,
  input  vma_pkg::lane_ops_t                 ops,
  output logic signed [vma_pkg::SUM_W-1:0]   sum
);
  import vma_pkg::*;

  logic signed [PROD_W-1:0] prod [NUM_TERMS];
  logic signed [SUM_W-1:0]  sum_next;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        prod[i] <= $signed(ops.m[i]) * $signed(ops.n[i]);
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NUM_TERMS; i++) begin
      sum_next = sum_next + {{(SUM_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      sum <= sum_next;
    end
  end

endmodule

[hdl/vma_merge.sv]
// rounding, saturation and merge of lane sums into the output word register
`timescale 1ns / 1ps

module vma_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          sum_valid,
  input  vma_pkg::op_t                                  sum_op,
  input  logic signed [vma_pkg::NUM_LANES-1:0][vma_pkg::SUM_W-1:0] sums,
  output logic                                          free,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic signed [15:0]                            rx,
  output logic signed [15:0]                            ry,
  output logic signed [15:0]                            rz,
  output logic signed [15:0]                            rw,
  output logic signed [15:0]                            scalar,
  output logic                                          saturated
);
  import vma_pkg::*;

  logic signed [COMP_W-1:0] res   [NUM_LANES];
  logic [NUM_LANES-1:0]     clip;
  logic signed [COMP_W-1:0] rx_next;
  logic signed [COMP_W-1:0] ry_next;
  logic signed [COMP_W-1:0] rz_next;
  logic signed [COMP_W-1:0] rw_next;
  logic signed [COMP_W-1:0] scalar_next;
  logic                     saturated_next;

  assign free = !out_valid || out_ready;

  always_comb begin
    logic signed [SUM_W-1:0]  rnd;
    logic signed [QUOT_W-1:0] q;
    for (int k = 0; k < NUM_LANES; k++) begin
      rnd = sums[k] + RND_HALF;
      q   = rnd[SUM_W-1:FRAC_W];
      if (q > QUOT_W'(COMP_MAX)) begin
        res[k]  = COMP_MAX;
        clip[k] = 1'b1;
      end else if (q < QUOT_W'(COMP_MIN)) begin
        res[k]  = COMP_MIN;
        clip[k] = 1'b1;
      end else begin
        res[k]  = q[COMP_W-1:0];
        clip[k] = 1'b0;
      end
    end
  end

  always_comb begin
    rx_next        = res[0];
    ry_next        = res[1];
    rz_next        = res[2];
    rw_next        = ONE_Q88;
    scalar_next    = '0;
    saturated_next = |clip[2:0];
    case (sum_op)
      OP_DOT: begin
        rx_next        = '0;
        ry_next        = '0;
        rz_next        = '0;
        scalar_next    = res[0];
        saturated_next = clip[0];
      end
      OP_XFORM: begin
        rw_next        = res[3];
        saturated_next = |clip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && sum_valid) begin
      rx        <= rx_next;
      ry        <= ry_next;
      rz        <= rz_next;
      rw        <= rw_next;
      scalar    <= scalar_next;
      saturated <= saturated_next;
    end
  end

endmodule
